/* design/bcad_pkg.sv */
// package for the bcd capable add/subtract alu
// holds the operation codes, nibble constants and the stage payload types
// no dependencies; used by every stage module and the top level
`default_nettype none

package bcad_pkg;

    // widths of the byte and nibble datapaths
    localparam int DataW = 8;
    localparam int NibW  = 4;

    // packed bcd constants
    localparam logic [4:0] BcdMaxDigit = 5'd9;
    localparam logic [5:0] BcdFixWide  = 6'd6;
    localparam logic [3:0] BcdFixNib   = 4'd6;

    // operation codes
    typedef enum logic {
        OP_ADC = 1'b0,
        OP_SBC = 1'b1
    } op_t;

    // one input item
    typedef struct packed {
        op_t              op;
        logic [DataW-1:0] accumulator;
        logic [DataW-1:0] operand;
        logic             carry_in;
        logic             decimal_mode;
    } in_item_t;

    // after the first stage: raw low nibble and full binary sum
    typedef struct packed {
        op_t             op;
        logic            dec;
        logic [NibW-1:0] a_hi;
        logic [NibW-1:0] b_hi;
        logic [DataW:0]  bin_sum;
        logic [NibW:0]   lo_raw;
    } s1_t;

    // after the second stage: binary flags, corrected low nibble, raw high nibble
    typedef struct packed {
        op_t              op;
        logic             dec;
        logic [DataW-1:0] bin_byte;
        logic             bin_c;
        logic             bin_v;
        logic             bin_z;
        logic             bin_n;
        logic [NibW-1:0]  lo_fix;
        logic [NibW:0]    hi_raw;
        logic             dadd_n;
        logic             dadd_v;
    } s2_t;

    // one result item, with the mode bit kept for checking
    typedef struct packed {
        logic [DataW-1:0] sum_out;
        logic             carry_out;
        logic             overflow;
        logic             zero;
        logic             negative;
        logic             dec;
    } res_t;

endpackage

`default_nettype wire

/* design/bcad_split_stage.sv */
// first pipeline stage: low nibble add or subtract and the binary byte sum
// depends on bcad_pkg
`default_nettype none

module bcad_split_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire bcad_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output bcad_pkg::s1_t           out_data
);

    logic          valid_reg;
    bcad_pkg::s1_t data_reg;
    bcad_pkg::s1_t data_next;
    logic [bcad_pkg::DataW-1:0] b_eff;

    // stage advances when empty or when the next stage takes its item
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // binary sum uses the inverted operand for subtract
    always_comb
    begin
        b_eff = (in_data.op == bcad_pkg::OP_SBC) ? ~in_data.operand : in_data.operand;
        data_next.op      = in_data.op;
        data_next.dec     = in_data.decimal_mode;
        data_next.a_hi    = in_data.accumulator[7:4];
        data_next.b_hi    = in_data.operand[7:4];
        data_next.bin_sum = {1'b0, in_data.accumulator} + {1'b0, b_eff}
                          + {{bcad_pkg::DataW{1'b0}}, in_data.carry_in};
        if (in_data.op == bcad_pkg::OP_SBC)
        begin
            data_next.lo_raw = {1'b0, in_data.accumulator[3:0]}
                             - {1'b0, in_data.operand[3:0]}
                             - {{bcad_pkg::NibW{1'b0}}, ~in_data.carry_in};
        end
        else
        begin
            data_next.lo_raw = {1'b0, in_data.accumulator[3:0]}
                             + {1'b0, in_data.operand[3:0]}
                             + {{bcad_pkg::NibW{1'b0}}, in_data.carry_in};
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* design/bcad_carry_stage.sv */
// second pipeline stage: binary flags, low nibble correction, raw high nibble
// depends on bcad_pkg
`default_nettype none

module bcad_carry_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire bcad_pkg::s1_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output bcad_pkg::s2_t      out_data
);

    logic          valid_reg;
    bcad_pkg::s2_t data_reg;
    bcad_pkg::s2_t data_next;
    logic [5:0]    lo_wide;
    logic          lo_cy;
    logic          a7;
    logic          b7;
    logic          r7;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        a7 = in_data.a_hi[3];
        b7 = in_data.b_hi[3];
        r7 = in_data.bin_sum[7];

        // binary flags
        data_next.op       = in_data.op;
        data_next.dec      = in_data.dec;
        data_next.bin_byte = in_data.bin_sum[7:0];
        data_next.bin_c    = in_data.bin_sum[8];
        data_next.bin_z    = (in_data.bin_sum[7:0] == '0);
        data_next.bin_n    = r7;
        if (in_data.op == bcad_pkg::OP_SBC)
        begin
            data_next.bin_v = (a7 ^ r7) & (a7 ^ b7);
        end
        else
        begin
            data_next.bin_v = ~(a7 ^ b7) & (a7 ^ r7);
        end

        // decimal add low nibble correction and carry into the high nibble
        lo_wide = (in_data.lo_raw > bcad_pkg::BcdMaxDigit)
                ? ({1'b0, in_data.lo_raw} + bcad_pkg::BcdFixWide)
                : {1'b0, in_data.lo_raw};
        lo_cy   = (lo_wide[5:4] != 2'b00);

        if (in_data.op == bcad_pkg::OP_SBC)
        begin
            // decimal subtract: a negative low nibble borrows from the high one
            data_next.lo_fix = in_data.lo_raw[4] ? (in_data.lo_raw[3:0] - bcad_pkg::BcdFixNib)
                                                 : in_data.lo_raw[3:0];
            data_next.hi_raw = {1'b0, in_data.a_hi} - {1'b0, in_data.b_hi}
                             - {{bcad_pkg::NibW{1'b0}}, in_data.lo_raw[4]};
        end
        else
        begin
            data_next.lo_fix = lo_wide[3:0];
            data_next.hi_raw = {1'b0, in_data.a_hi} + {1'b0, in_data.b_hi}
                             + {{bcad_pkg::NibW{1'b0}}, lo_cy};
        end

        // decimal add takes n and v from the high nibble before correction
        data_next.dadd_n = data_next.hi_raw[3];
        data_next.dadd_v = (data_next.hi_raw[3] ^ a7) & ~(a7 ^ b7);
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* design/bcad_fix_stage.sv */
// third pipeline stage: high nibble correction and result selection
// depends on bcad_pkg; its register is the output register of the block
`default_nettype none

module bcad_fix_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire bcad_pkg::s2_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output bcad_pkg::res_t     out_data
);

    logic           valid_reg;
    bcad_pkg::res_t data_reg;
    bcad_pkg::res_t data_next;
    logic [5:0]     hi_wide;
    logic [3:0]     hi_sub;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        // decimal add and subtract high nibble corrections
        hi_wide = (in_data.hi_raw > bcad_pkg::BcdMaxDigit)
                ? ({1'b0, in_data.hi_raw} + bcad_pkg::BcdFixWide)
                : {1'b0, in_data.hi_raw};
        hi_sub  = in_data.hi_raw[4] ? (in_data.hi_raw[3:0] - bcad_pkg::BcdFixNib)
                                    : in_data.hi_raw[3:0];

        data_next.dec = in_data.dec;
        if (in_data.op == bcad_pkg::OP_SBC)
        begin
            // subtract keeps binary flags in either mode
            data_next.sum_out   = in_data.dec ? {hi_sub, in_data.lo_fix} : in_data.bin_byte;
            data_next.carry_out = in_data.bin_c;
            data_next.overflow  = in_data.bin_v;
            data_next.zero      = in_data.bin_z;
            data_next.negative  = in_data.bin_n;
        end
        else if (in_data.dec)
        begin
            data_next.sum_out   = {hi_wide[3:0], in_data.lo_fix};
            data_next.carry_out = (hi_wide[5:4] != 2'b00);
            data_next.overflow  = in_data.dadd_v;
            data_next.zero      = in_data.bin_z;
            data_next.negative  = in_data.dadd_n;
        end
        else
        begin
            data_next.sum_out   = in_data.bin_byte;
            data_next.carry_out = in_data.bin_c;
            data_next.overflow  = in_data.bin_v;
            data_next.zero      = in_data.bin_z;
            data_next.negative  = in_data.bin_n;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* design/bcd_capable_add_subtract_alu.sv */
// top level of the bcd capable add/subtract alu
// depends on bcad_pkg, bcad_split_stage, bcad_carry_stage and bcad_fix_stage
//
// usage
//   s_* carries one operation per item: accumulator, operand and carry in
//   in s_tdata, the operation and the decimal mode flag in s_tuser.
//   m_* returns one result item per operation: new accumulator and the
//   carry, overflow, zero and negative flags in m_tdata.
//   binary mode is a plain 8-bit adder/subtractor; decimal mode corrects each
//   nibble by 6 and keeps the nmos flag behaviour (decimal add: zero from the
//   binary sum, negative and overflow from the uncorrected high nibble;
//   decimal subtract: every flag from the binary difference).
//   every item passes the three register stages (low nibble, high nibble,
//   correction and select) on its way from acceptance to m_tvalid.
//   throughput is one item per cycle while the receiver does not stall; results come out in input order.
//   when the receiver stalls each stage holds its item and s_tready falls
//   only once all three stages are full; nothing is lost or repeated.
//   reset empties the pipeline at once; no item is in flight afterwards.
`default_nettype none

module bcd_capable_add_subtract_alu (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // accumulator [7:0], operand [15:8], carry_in [16], zero pad [23:17]
    input  wire logic [23:0] s_tdata,
    // op [0], decimal_mode [1]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // sum_out [7:0], carry_out [8], overflow [9], zero [10], negative [11], zero pad [15:12]
    output logic [15:0]      m_tdata
);

    bcad_pkg::in_item_t in_item;
    bcad_pkg::s1_t      s1_data;
    bcad_pkg::s2_t      s2_data;
    bcad_pkg::res_t     res_data;
    logic               s1_valid;
    logic               s1_ready;
    logic               s2_valid;
    logic               s2_ready;

    // unpack the input item
    always_comb
    begin
        in_item.op           = bcad_pkg::op_t'(s_tuser[0]);
        in_item.decimal_mode = s_tuser[1];
        in_item.accumulator  = s_tdata[7:0];
        in_item.operand      = s_tdata[15:8];
        in_item.carry_in     = s_tdata[16];
    end

    // pipeline stages
    bcad_split_stage u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (in_item),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    bcad_carry_stage u_carry (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    bcad_fix_stage u_fix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_data)
    );

    // pack the result item
    assign m_tdata = {4'b0000, res_data.negative, res_data.zero, res_data.overflow,
                      res_data.carry_out, res_data.sum_out};

    // an empty first stage always takes an item
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid |-> s_tready)
        else $error("input not ready while first stage empty");

    // an accepted item reaches the first stage register
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> s1_valid)
        else $error("accepted item lost at first stage");

    // an item handed from the second stage appears at the output
    a_handoff_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid && s2_ready) |=> m_tvalid)
        else $error("item lost between second stage and output");

    // binary results carry zero and negative from the result byte
    a_binary_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !res_data.dec) |->
            ((res_data.zero == (res_data.sum_out == '0)) &&
             (res_data.negative == res_data.sum_out[7])))
        else $error("binary zero or negative flag mismatch");

endmodule

`default_nettype wire
